FILE: rtl/aes_feedback_byte_generator_core_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the feedback byte generator
// expand to concurrent assertions in simulation, to nothing in synthesis
// ----------------------------------------------------------------------------
`ifndef AES_FEEDBACK_BYTE_GENERATOR_CORE_DEFINES_SVH
`define AES_FEEDBACK_BYTE_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define AFB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AFB_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define AFB_ASSERT(label, clk, rst_n, prop, msg)
`define AFB_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

FILE: rtl/afbg_pkg.sv
// ----------------------------------------------------------------------------
// afbg_pkg
// shared types, constants and aes helper functions
// ----------------------------------------------------------------------------
package afbg_pkg;

	localparam int BLOCK_W = 128;
	localparam int KEY_W = 64;
	localparam int ROUNDS = 10;

	localparam logic [0:0] REG_KEY_HIGH = 1'b0;
	localparam logic [0:0] REG_KEY_LOW = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load_key;   // latch round key 0, start key schedule
		logic incr;       // counter bump and initial add round key
		logic round;      // one aes round
		logic last_round; // skip mixcolumns
	} afbg_cmd_t;

	typedef logic [7:0] byte_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic byte_t xt(input byte_t x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of a block sits in bits 127-8i .. 120-8i
	function automatic byte_t blk_byte(input logic [BLOCK_W-1:0] b, input int i);
		return b[BLOCK_W-1-8*i -: 8];
	endfunction

endpackage

FILE: rtl/afbg_datapath.sv
// ----------------------------------------------------------------------------
// afbg_datapath
// feedback block, key schedule and one aes round per cycle
// ----------------------------------------------------------------------------
module afbg_datapath import afbg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 key_wr,
	input  logic                 key_sel,
	input  logic [KEY_W-1:0]     key_data,
	input  afbg_cmd_t            cmd,
	output logic [7:0]           out_byte
);

	logic [KEY_W-1:0]   key_high_q, key_low_q;
	logic [BLOCK_W-1:0] state_q;
	logic [BLOCK_W-1:0] rk_q;
	logic [7:0]         rcon_q;
	logic [BLOCK_W-1:0] rk_next, key0, ctr_blk, sr_blk, mc_blk, rnd_blk;
	logic [31:0]        ctr;

	assign key0 = {key_high_q, key_low_q};

	// next round key from current one
	always_comb begin
		logic [31:0] t;
		logic [31:0] w0, w1, w2, w3;
		t = {SBOX[rk_q[23:16]] ^ rcon_q, SBOX[rk_q[15:8]], SBOX[rk_q[7:0]],
			SBOX[rk_q[31:24]]};
		w0 = rk_q[127:96] ^ t;
		w1 = rk_q[95:64] ^ w0;
		w2 = rk_q[63:32] ^ w1;
		w3 = rk_q[31:0] ^ w2;
		rk_next = {w0, w1, w2, w3};
	end

	// little-endian counter in bytes 0..3, then add round key 0
	assign ctr = {state_q[103:96], state_q[111:104], state_q[119:112],
		state_q[127:120]} + 32'd1;
	assign ctr_blk = {ctr[7:0], ctr[15:8], ctr[23:16], ctr[31:24], state_q[95:0]}
		^ key0;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				sr_blk[BLOCK_W-1-8*(i+4*c) -: 8] =
					SBOX[blk_byte(state_q, i + 4*((c + i) % 4))];
			end
		end
		for (int c = 0; c < 4; c++) begin
			byte_t a0, a1, a2, a3, t;
			a0 = blk_byte(sr_blk, 4*c);
			a1 = blk_byte(sr_blk, 4*c+1);
			a2 = blk_byte(sr_blk, 4*c+2);
			a3 = blk_byte(sr_blk, 4*c+3);
			t = a0 ^ a1 ^ a2 ^ a3;
			mc_blk[BLOCK_W-1-32*c -: 32] = {a0 ^ t ^ xt(a0 ^ a1), a1 ^ t ^ xt(a1 ^ a2),
				a2 ^ t ^ xt(a2 ^ a3), a3 ^ t ^ xt(a3 ^ a0)};
		end
		rnd_blk = (cmd.last_round ? sr_blk : mc_blk) ^ rk_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			state_q <= '0;
		end else if (key_wr) begin
			if (key_sel == REG_KEY_HIGH) key_high_q <= key_data;
			else key_low_q <= key_data;
			state_q <= '0;
		end else if (cmd.incr) begin
			state_q <= ctr_blk;
		end else if (cmd.round) begin
			state_q <= rnd_blk;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			rk_q <= key0;
			rcon_q <= 8'h01;
		end else if (cmd.round) begin
			rk_q <= rk_next;
			rcon_q <= xt(rcon_q);
		end
	end

	assign out_byte = state_q[127:120];

endmodule

FILE: rtl/afbg_ctrl.sv
// ----------------------------------------------------------------------------
// afbg_ctrl
// run counter and round sequencer
// ----------------------------------------------------------------------------
module afbg_ctrl import afbg_pkg::*; #(
	parameter int MAX_RUN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [6:0] in_count,
	output logic       in_rdy,
	output afbg_cmd_t  cmd,
	output logic       byte_done,
	output logic       byte_last,
	input  logic       out_free
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INCR = 2'd1;
	localparam logic [1:0] ST_RND  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;
	localparam int CW = $clog2(MAX_RUN + 1);

	logic [1:0]    state_q;
	logic [3:0]    round_q;
	logic [CW-1:0] remain_q;
	logic [CW-1:0] cnt_sat;

	assign cnt_sat = (32'(in_count) > MAX_RUN) ? CW'(MAX_RUN) : CW'(in_count);
	assign in_rdy = (state_q == ST_IDLE);

	// round key 0 is reloaded for every byte of the run
	always_comb begin
		cmd = '0;
		cmd.load_key = (state_q == ST_INCR);
		cmd.incr = (state_q == ST_INCR);
		cmd.round = (state_q == ST_RND);
		cmd.last_round = (round_q == 4'(ROUNDS));
	end

	assign byte_done = (state_q == ST_EMIT) && out_free;
	assign byte_last = (remain_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			remain_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && cnt_sat != '0) begin
						remain_q <= cnt_sat;
						state_q <= ST_INCR;
					end
				end
				ST_INCR: begin
					round_q <= 4'd1;
					state_q <= ST_RND;
				end
				ST_RND: begin
					round_q <= round_q + 4'd1;
					if (round_q == 4'(ROUNDS)) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						remain_q <= remain_q - CW'(1);
						state_q <= byte_last ? ST_IDLE : ST_INCR;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/aes_feedback_byte_generator_core.sv
// a new item is taken only in idle, once the last byte of the previous run
// has gone to the output register; each byte is made by the single
//   shared aes round unit (one round per cycle, key schedule on the fly)
// reset clears keys, feedback block and control; key writes clear the block
// ----------------------------------------------------------------------------
// aes_feedback_byte_generator_core
// aes-128 counter feedback byte generator, top level
// ----------------------------------------------------------------------------
`include "aes_feedback_byte_generator_core_defines.svh"
module aes_feedback_byte_generator_core import afbg_pkg::*; #(
	parameter int MAX_RUN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [6:0] byte_count
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] random_byte
	output logic        m_axis_tlast,   // last_of_run
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	afbg_cmd_t  cmd;
	logic       in_fire, byte_done, byte_last, out_free;
	logic [7:0] out_byte;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	afbg_ctrl #(.MAX_RUN(MAX_RUN)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_count(s_axis_tdata[6:0]),
		.in_rdy(s_axis_tready), .cmd(cmd), .byte_done(byte_done),
		.byte_last(byte_last), .out_free(out_free)
	);

	afbg_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .key_wr(cfg_we), .key_sel(cfg_index),
		.key_data(cfg_wdata), .cmd(cmd), .out_byte(out_byte)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (byte_done) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_done) begin
			m_axis_tdata <= out_byte;
			m_axis_tlast <= byte_last;
		end
	end

	`AFB_ASSERT(a_done_free, clk, arst_n, byte_done |-> out_free, "byte done while output busy")
	`AFB_ASSERT_NEVER(a_cmd_excl, clk, arst_n, cmd.incr && cmd.round, "incr and round together")
	`AFB_ASSERT(a_no_accept_busy, clk, arst_n, byte_done |-> !s_axis_tready, "ready while busy")

endmodule

FILE: tb/sv/aes_feedback_byte_generator_core_tb.sv
// ----------------------------------------------------------------------------
// aes_feedback_byte_generator_core_tb
// drives byte-count requests into the generator under several keys, predicts
// every random byte with a local aes-128 counter feedback model and checks the
// byte stream and its run boundaries, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module aes_feedback_byte_generator_core_tb;
	import afbg_pkg::*;

	localparam int RUN_MAX = 64;
	localparam int N_RANDOM = 400;

	typedef struct packed {
		logic [7:0] rbyte;
		logic       last;
	} gen_byte_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [63:0] cfg_wdata;

	aes_feedback_byte_generator_core #(.MAX_RUN(RUN_MAX)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// model state
	logic [63:0]  key_hi_q, key_lo_q;
	logic [127:0] fb_block;

	logic [6:0]  count_q[$];
	gen_byte_t   expected_bytes[$];
	int          errors;
	int          hold_off;

	function automatic logic [7:0] sb(input logic [7:0] x);
		return SBOX[x];
	endfunction

	function automatic logic [7:0] dbl(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// one counter bump and encryption of the feedback block; byte i at bits 127-8i
	function automatic logic [127:0] next_block(input logic [127:0] b,
			input logic [63:0] khi, input logic [63:0] klo);
		logic [7:0] rk[176];
		logic [7:0] s[16];
		logic [7:0] n[16];
		logic [7:0] t[4];
		logic [7:0] tmp, rc, a0, a1, a2, a3, x;
		logic [31:0] ctr;
		logic [127:0] res;
		for (int i = 0; i < 8; i++) begin
			rk[i] = khi[63-8*i -: 8];
			rk[i+8] = klo[63-8*i -: 8];
		end
		rc = 8'h01;
		for (int i = 16; i < 176; i += 4) begin
			for (int j = 0; j < 4; j++) t[j] = rk[i-4+j];
			if (i % 16 == 0) begin
				tmp = t[0];
				t[0] = sb(t[1]) ^ rc;
				t[1] = sb(t[2]);
				t[2] = sb(t[3]);
				t[3] = sb(tmp);
				rc = dbl(rc);
			end
			for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ t[j];
		end
		for (int i = 0; i < 16; i++) s[i] = b[127-8*i -: 8];
		ctr = {s[3], s[2], s[1], s[0]} + 32'd1;
		{s[3], s[2], s[1], s[0]} = ctr;
		for (int i = 0; i < 16; i++) s[i] ^= rk[i];
		for (int r = 1; r <= 10; r++) begin
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					n[i+4*c] = sb(s[i + 4*((c+i) % 4)]);
			if (r != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = n[4*c]; a1 = n[4*c+1]; a2 = n[4*c+2]; a3 = n[4*c+3];
					x = a0 ^ a1 ^ a2 ^ a3;
					n[4*c]   = a0 ^ x ^ dbl(a0 ^ a1);
					n[4*c+1] = a1 ^ x ^ dbl(a1 ^ a2);
					n[4*c+2] = a2 ^ x ^ dbl(a2 ^ a3);
					n[4*c+3] = a3 ^ x ^ dbl(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) s[i] = n[i] ^ rk[16*r+i];
		end
		for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
		return res;
	endfunction

	task automatic predict_run(input logic [6:0] cnt);
		int len;
		gen_byte_t g;
		len = (cnt > RUN_MAX) ? RUN_MAX : cnt;
		for (int k = 0; k < len; k++) begin
			fb_block = next_block(fb_block, key_hi_q, key_lo_q);
			g.rbyte = fb_block[127:120];
			g.last = (k == len - 1);
			expected_bytes.push_back(g);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_run(s_axis_tdata[6:0]);
				void'(count_q.pop_front());
				send_gap = $urandom_range(0, 18);
				if ($urandom_range(0, 3) == 0) send_gap = 0;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold
			end else if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (count_q.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {1'b0, count_q[0]};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	int stall;
	gen_byte_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected item: random_byte %h", m_axis_tdata);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (m_axis_tdata !== want.rbyte) begin
						$error("random_byte expected %h actual %h", want.rbyte, m_axis_tdata);
						errors++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last_of_run expected %b actual %b", want.last, m_axis_tlast);
						errors++;
					end
				end
				stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
			end
			if (hold_off > 0) begin
				hold_off--;
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic drain();
		while (count_q.size() > 0 || s_axis_tvalid || expected_bytes.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_KEY_HIGH) key_hi_q = val;
		else key_lo_q = val;
		fb_block = '0;
	endtask

	task automatic random_requests(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				count_q.push_back(7'($urandom_range(0, 127)));
			else if ($urandom_range(0, 7) == 0)
				count_q.push_back(7'($urandom_range(56, 64)));
			else
				count_q.push_back(7'($urandom_range(1, 8)));
		end
	endtask

	initial begin
		logic [63:0] r;
		errors = 0;
		hold_off = 0;
		key_hi_q = '0;
		key_lo_q = '0;
		fb_block = '0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_HIGH;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// zero key, directed counts incl. zero, saturation and the top bit
		count_q.push_back(7'd1);
		count_q.push_back(7'd0);
		count_q.push_back(7'd2);
		count_q.push_back(7'd64);
		count_q.push_back(7'd65);
		count_q.push_back(7'd127);
		count_q.push_back(7'd85);
		count_q.push_back(7'd42);
		count_q.push_back(7'd0);
		count_q.push_back(7'd3);
		drain();

		// all-ones key, rewrite of an unchanged value still clears the block
		write_key(REG_KEY_HIGH, '1);
		write_key(REG_KEY_LOW, '1);
		count_q.push_back(7'd5);
		drain();
		write_key(REG_KEY_LOW, '1);
		count_q.push_back(7'd5);
		count_q.push_back(7'd1);
		drain();

		// long receiver stall while the sender keeps offering items
		hold_off = 2000;
		for (int i = 0; i < 8; i++) count_q.push_back(7'd4);
		drain();

		// random phases under random keys, ending with the all-zero key
		for (int p = 0; p < 4; p++) begin
			r = {$urandom, $urandom};
			write_key(REG_KEY_HIGH, p == 3 ? 64'd0 : r);
			r = {$urandom, $urandom};
			write_key(REG_KEY_LOW, p == 3 ? 64'd0 : r);
			random_requests(N_RANDOM / 4);
			drain();
		end

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#100000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
